// ===== sv/half_neighbor_list_scan_assert.svh =====
// Assertion macros shared by the checker of the neighbor list scan.
// Depends on nothing; the using module provides clk and rst_n.
`ifndef HALF_NEIGHBOR_LIST_SCAN_ASSERT_SVH
`define HALF_NEIGHBOR_LIST_SCAN_ASSERT_SVH

// Same-cycle implication.
`define HNL_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication with a fixed delay in cycles.
`define HNL_ASSERT_DELAY(lbl, ante, n, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ## n (cons)) \
    else $error(msg);

`endif

// ===== sv/hnl_pkg.sv =====
// Shared types and constants of the half neighbor list scan.
// No dependencies.
package hnl_pkg;

  localparam int COORD_W = 24;
  localparam int DIFF_W  = 26;
  localparam int DIST_W  = 52;
  localparam int SLOT_W  = 10;
  localparam int IDX_W   = 10;

  localparam logic [1:0] OP_LOAD_POS   = 2'd0;
  localparam logic [1:0] OP_LOAD_TRANS = 2'd1;
  localparam logic [1:0] OP_SCAN       = 2'd2;

  localparam logic [1:0] REG_CUTOFF_SQ   = 2'd0;
  localparam logic [1:0] REG_ATOM_COUNT  = 2'd1;
  localparam logic [1:0] REG_TRANS_COUNT = 2'd2;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    CMD_LOAD_POS,
    CMD_LOAD_TRANS,
    CMD_SCAN
  } cmd_kind_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] z;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] x;
  } vec_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [SLOT_W-1:0] slot;
    vec_t              vec;
  } cmd_t;

  function automatic logic signed [DIFF_W-1:0] sx_diff(input logic signed [COORD_W-1:0] v);
    return {{(DIFF_W-COORD_W){v[COORD_W-1]}}, v};
  endfunction

endpackage

// ===== sv/hnl_front.sv =====
// Front end: accepts command words, drops ignored ones and classifies the rest.
// Depends on hnl_pkg; feeds hnl_queue.
module hnl_front #(
  parameter int MAX_ATOMS = 1024,
  parameter int MAX_TRANS = 256
) (
  input  logic                               start,
  input  logic [1:0]                         in_op,
  input  logic [hnl_pkg::SLOT_W-1:0]         in_slot,
  input  logic signed [hnl_pkg::COORD_W-1:0] in_coord_x,
  input  logic signed [hnl_pkg::COORD_W-1:0] in_coord_y,
  input  logic signed [hnl_pkg::COORD_W-1:0] in_coord_z,
  input  logic                               q_full,
  output logic                               busy,
  output logic                               q_push,
  output hnl_pkg::cmd_t                      q_data
);

  logic accept;
  logic keep;

  assign busy   = q_full;
  assign accept = start && !q_full;

  always_comb begin
    keep             = 1'b0;
    q_data.kind      = hnl_pkg::CMD_SCAN;
    q_data.slot      = in_slot;
    q_data.vec.x     = in_coord_x;
    q_data.vec.y     = in_coord_y;
    q_data.vec.z     = in_coord_z;
    unique case (in_op)
      hnl_pkg::OP_LOAD_POS: begin
        q_data.kind = hnl_pkg::CMD_LOAD_POS;
        keep        = 32'(in_slot) < MAX_ATOMS;
      end
      hnl_pkg::OP_LOAD_TRANS: begin
        q_data.kind = hnl_pkg::CMD_LOAD_TRANS;
        keep        = 32'(in_slot) < MAX_TRANS;
      end
      hnl_pkg::OP_SCAN: begin
        keep = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  // Drop out-of-range loads and unknown ops here.
  assign q_push = accept && keep;

endmodule

// ===== sv/hnl_queue.sv =====
// Short command queue between the front end and the scan engine.
// Depends on hnl_pkg.
module hnl_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  hnl_pkg::cmd_t push_data,
  output logic          full,
  input  logic          pop,
  output logic          valid,
  output hnl_pkg::cmd_t pop_data
);

  localparam int CNT_W = hnl_pkg::QPTR_W + 1;

  hnl_pkg::cmd_t                 entry_r [hnl_pkg::QUEUE_DEPTH];
  logic [hnl_pkg::QPTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [hnl_pkg::QPTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]              count_r, count_nxt;
  logic                          do_push, do_pop;

  assign full     = count_r == CNT_W'(hnl_pkg::QUEUE_DEPTH);
  assign valid    = count_r != '0;
  assign pop_data = entry_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (32'(wr_ptr_r) == hnl_pkg::QUEUE_DEPTH - 1) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (32'(rd_ptr_r) == hnl_pkg::QUEUE_DEPTH - 1) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== sv/hnl_back.sv =====
// Scan engine: position and translation stores, scan cursors and the
// four-stage distance pipeline. Depends on hnl_pkg; fed by hnl_queue.
module hnl_back #(
  parameter int MAX_ATOMS = 1024,
  parameter int MAX_TRANS = 256,
  localparam int IW  = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1,
  localparam int CW  = $clog2(MAX_ATOMS + 1),
  localparam int TW  = (MAX_TRANS > 1) ? $clog2(MAX_TRANS) : 1,
  localparam int TCW = (MAX_TRANS > 1) ? $clog2(MAX_TRANS + 1) : 1
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cmd_valid,
  input  hnl_pkg::cmd_t                      cmd,
  input  logic [hnl_pkg::DIST_W-1:0]         cutoff_sq,
  input  logic [CW-1:0]                      atom_lim,
  input  logic [TCW-1:0]                     trans_lim,
  output logic                               out_valid,
  output logic [hnl_pkg::IDX_W-1:0]          out_center,
  output logic [hnl_pkg::IDX_W-1:0]          out_neighbor,
  output logic signed [hnl_pkg::DIFF_W-1:0]  out_diff_x,
  output logic signed [hnl_pkg::DIFF_W-1:0]  out_diff_y,
  output logic signed [hnl_pkg::DIFF_W-1:0]  out_diff_z,
  output logic                               out_found,
  output logic                               out_scan_done
);

  localparam int DW = hnl_pkg::DIFF_W;
  localparam int SW = hnl_pkg::DIST_W;

  hnl_pkg::vec_t pos_mem [MAX_ATOMS];
  hnl_pkg::vec_t tr_mem  [MAX_TRANS];

  // Cursors
  logic [IW-1:0]  ci_r, ci_nxt, cur_i;
  logic [IW-1:0]  cj_r, cj_nxt, cur_j;
  logic [TW-1:0]  ct_r, ct_nxt, cur_t;
  logic [TCW-1:0] t_inc;
  logic [CW-1:0]  i_inc;
  logic           restart, same, last, do_scan;

  // Stage 1: store reads
  logic                       s1_valid_r;
  logic [hnl_pkg::IDX_W-1:0]  s1_i_r, s1_j_r;
  logic                       s1_same_r, s1_last_r;
  hnl_pkg::vec_t              s1_pi_r, s1_pj_r, s1_tr_r;

  // Stage 2: displacement
  logic                       s2_valid_r;
  logic [hnl_pkg::IDX_W-1:0]  s2_i_r, s2_j_r;
  logic                       s2_same_r, s2_last_r;
  logic signed [DW-1:0]       s2_dx_r, s2_dy_r, s2_dz_r;
  logic signed [DW-1:0]       dx_nxt, dy_nxt, dz_nxt;

  // Stage 3: squares
  logic                       s3_valid_r;
  logic [hnl_pkg::IDX_W-1:0]  s3_i_r, s3_j_r;
  logic                       s3_same_r, s3_last_r, s3_lex_r;
  logic signed [DW-1:0]       s3_dx_r, s3_dy_r, s3_dz_r;
  logic [SW-1:0]              s3_sx_r, s3_sy_r, s3_sz_r;
  logic signed [SW-1:0]       px, py, pz;
  logic                       lex_nxt;

  // Stage 4: compare
  logic [SW-1:0]              sq_sum;
  logic                       keep;

  assign do_scan = cmd_valid && (cmd.kind == hnl_pkg::CMD_SCAN);

  always_comb begin
    restart = (CW'(ci_r) >= atom_lim) || (cj_r > ci_r) || (TCW'(ct_r) >= trans_lim);
    cur_i   = restart ? '0 : ci_r;
    cur_j   = restart ? '0 : cj_r;
    cur_t   = restart ? '0 : ct_r;
    t_inc   = TCW'(cur_t) + TCW'(1);
    i_inc   = CW'(cur_i) + CW'(1);
    same    = cur_j == cur_i;
    ci_nxt  = cur_i;
    cj_nxt  = cur_j;
    ct_nxt  = t_inc[TW-1:0];
    last    = 1'b0;
    // Advance translation, then neighbor, then center.
    if (t_inc >= trans_lim) begin
      ct_nxt = '0;
      if (same) begin
        cj_nxt = '0;
        if (i_inc >= atom_lim) begin
          ci_nxt = '0;
          last   = 1'b1;
        end else begin
          ci_nxt = i_inc[IW-1:0];
        end
      end else begin
        cj_nxt = cur_j + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_valid && cmd.kind == hnl_pkg::CMD_LOAD_POS) begin
      pos_mem[IW'(cmd.slot)] <= cmd.vec;
    end
    if (cmd_valid && cmd.kind == hnl_pkg::CMD_LOAD_TRANS) begin
      tr_mem[TW'(cmd.slot)] <= cmd.vec;
    end
    s1_pi_r <= pos_mem[cur_i];
    s1_pj_r <= pos_mem[cur_j];
    s1_tr_r <= tr_mem[cur_t];
  end

  always_comb begin
    dx_nxt = hnl_pkg::sx_diff(s1_tr_r.x);
    dy_nxt = hnl_pkg::sx_diff(s1_tr_r.y);
    dz_nxt = hnl_pkg::sx_diff(s1_tr_r.z);
    // Self pairs use the translation alone.
    if (!s1_same_r) begin
      dx_nxt = dx_nxt + hnl_pkg::sx_diff(s1_pj_r.x) - hnl_pkg::sx_diff(s1_pi_r.x);
      dy_nxt = dy_nxt + hnl_pkg::sx_diff(s1_pj_r.y) - hnl_pkg::sx_diff(s1_pi_r.y);
      dz_nxt = dz_nxt + hnl_pkg::sx_diff(s1_pj_r.z) - hnl_pkg::sx_diff(s1_pi_r.z);
    end
  end

  always_comb begin
    px      = s2_dx_r * s2_dx_r;
    py      = s2_dy_r * s2_dy_r;
    pz      = s2_dz_r * s2_dz_r;
    lex_nxt = (s2_dz_r > 0) ||
              (s2_dz_r == 0 && s2_dy_r > 0) ||
              (s2_dz_r == 0 && s2_dy_r == 0 && s2_dx_r > 0);
  end

  always_comb begin
    sq_sum = s3_sx_r + s3_sy_r + s3_sz_r;
    keep   = (sq_sum != '0) && (sq_sum < cutoff_sq) && (!s3_same_r || s3_lex_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ci_r          <= '0;
      cj_r          <= '0;
      ct_r          <= '0;
      s1_valid_r    <= 1'b0;
      s2_valid_r    <= 1'b0;
      s3_valid_r    <= 1'b0;
      out_valid     <= 1'b0;
      out_found     <= 1'b0;
      out_scan_done <= 1'b0;
    end else begin
      if (do_scan) begin
        ci_r <= ci_nxt;
        cj_r <= cj_nxt;
        ct_r <= ct_nxt;
      end
      s1_valid_r    <= do_scan;
      s2_valid_r    <= s1_valid_r;
      s3_valid_r    <= s2_valid_r;
      out_valid     <= s3_valid_r;
      out_found     <= s3_valid_r && keep;
      out_scan_done <= s3_valid_r && s3_last_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_i_r    <= hnl_pkg::IDX_W'(cur_i);
    s1_j_r    <= hnl_pkg::IDX_W'(cur_j);
    s1_same_r <= same;
    s1_last_r <= last;

    s2_i_r    <= s1_i_r;
    s2_j_r    <= s1_j_r;
    s2_same_r <= s1_same_r;
    s2_last_r <= s1_last_r;
    s2_dx_r   <= dx_nxt;
    s2_dy_r   <= dy_nxt;
    s2_dz_r   <= dz_nxt;

    s3_i_r    <= s2_i_r;
    s3_j_r    <= s2_j_r;
    s3_same_r <= s2_same_r;
    s3_last_r <= s2_last_r;
    s3_lex_r  <= lex_nxt;
    s3_dx_r   <= s2_dx_r;
    s3_dy_r   <= s2_dy_r;
    s3_dz_r   <= s2_dz_r;
    s3_sx_r   <= $unsigned(px);
    s3_sy_r   <= $unsigned(py);
    s3_sz_r   <= $unsigned(pz);

    // Zero the payload of a miss.
    out_center   <= keep ? s3_i_r : '0;
    out_neighbor <= keep ? s3_j_r : '0;
    out_diff_x   <= keep ? s3_dx_r : '0;
    out_diff_y   <= keep ? s3_dy_r : '0;
    out_diff_z   <= keep ? s3_dz_r : '0;
  end

endmodule

// ===== sv/half_neighbor_list_scan.sv =====
// Top level of the half neighbor list scan: configuration registers and
// the front end, command queue and scan engine. Depends on hnl_pkg,
// hnl_front, hnl_queue and hnl_back.
//
// Usage:
//   Commands enter on start/in_* and are taken at an edge where start is
//   high and busy is low. Op 0 loads an atom position, op 1 a lattice
//   translation, op 2 tests the next candidate of the scan order (center i,
//   neighbor j <= i, translation t). Loads with a slot beyond the store and
//   op 3 are dropped and give no word.
//   Each op 2 gives exactly one word, strobed by out_valid for one cycle,
//   after the queue and the pipeline; out_found marks a kept pair and
//   out_scan_done the last candidate, after which the scan starts over.
//   Throughput is one command per cycle unless busy; the stores read both
//   positions and the translation at once; squares sit in their own stage.
//   The receiver cannot stall; every word must be taken when strobed.
//   Configuration is written on cfg_we/cfg_index/cfg_data while idle.
//   Reset clears cursors, pipeline and queue and sets cutoff_sq to 0 and
//   both counts to 1; store contents are undefined until loaded.
module half_neighbor_list_scan #(
  parameter int MAX_ATOMS = 1024,
  parameter int MAX_TRANS = 256
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [1:0]                         in_op,
  input  logic [hnl_pkg::SLOT_W-1:0]         in_slot,
  input  logic signed [hnl_pkg::COORD_W-1:0] in_coord_x,
  input  logic signed [hnl_pkg::COORD_W-1:0] in_coord_y,
  input  logic signed [hnl_pkg::COORD_W-1:0] in_coord_z,
  input  logic                               cfg_we,
  input  logic [1:0]                         cfg_index,
  input  logic [hnl_pkg::DIST_W-1:0]         cfg_data,
  output logic                               out_valid,
  output logic [hnl_pkg::IDX_W-1:0]          out_center,
  output logic [hnl_pkg::IDX_W-1:0]          out_neighbor,
  output logic signed [hnl_pkg::DIFF_W-1:0]  out_diff_x,
  output logic signed [hnl_pkg::DIFF_W-1:0]  out_diff_y,
  output logic signed [hnl_pkg::DIFF_W-1:0]  out_diff_z,
  output logic                               out_found,
  output logic                               out_scan_done
);

  localparam int CW  = $clog2(MAX_ATOMS + 1);
  localparam int TCW = (MAX_TRANS > 1) ? $clog2(MAX_TRANS + 1) : 1;

  logic [hnl_pkg::DIST_W-1:0] cutoff_r;
  logic [CW-1:0]              atom_lim_r, atom_lim_nxt;
  logic [TCW-1:0]             trans_lim_r, trans_lim_nxt;
  logic [31:0]                atom_req, trans_req;

  logic          q_push, q_full, q_valid;
  hnl_pkg::cmd_t q_in, q_out;

  // Clamp counts into 1..store depth when written.
  always_comb begin
    atom_req  = 32'(cfg_data[10:0]);
    trans_req = 32'(cfg_data[8:0]);
    if (atom_req == 0) begin
      atom_lim_nxt = CW'(1);
    end else if (atom_req > MAX_ATOMS) begin
      atom_lim_nxt = CW'(MAX_ATOMS);
    end else begin
      atom_lim_nxt = CW'(atom_req);
    end
    if (trans_req == 0) begin
      trans_lim_nxt = TCW'(1);
    end else if (trans_req > MAX_TRANS) begin
      trans_lim_nxt = TCW'(MAX_TRANS);
    end else begin
      trans_lim_nxt = TCW'(trans_req);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cutoff_r    <= '0;
      atom_lim_r  <= CW'(1);
      trans_lim_r <= TCW'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        hnl_pkg::REG_CUTOFF_SQ:   cutoff_r    <= cfg_data;
        hnl_pkg::REG_ATOM_COUNT:  atom_lim_r  <= atom_lim_nxt;
        hnl_pkg::REG_TRANS_COUNT: trans_lim_r <= trans_lim_nxt;
        default: ;
      endcase
    end
  end

  hnl_front #(
    .MAX_ATOMS(MAX_ATOMS),
    .MAX_TRANS(MAX_TRANS)
  ) u_front (
    .start      (start),
    .in_op      (in_op),
    .in_slot    (in_slot),
    .in_coord_x (in_coord_x),
    .in_coord_y (in_coord_y),
    .in_coord_z (in_coord_z),
    .q_full     (q_full),
    .busy       (busy),
    .q_push     (q_push),
    .q_data     (q_in)
  );

  hnl_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_valid),
    .valid     (q_valid),
    .pop_data  (q_out)
  );

  hnl_back #(
    .MAX_ATOMS(MAX_ATOMS),
    .MAX_TRANS(MAX_TRANS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd_valid     (q_valid),
    .cmd           (q_out),
    .cutoff_sq     (cutoff_r),
    .atom_lim      (atom_lim_r),
    .trans_lim     (trans_lim_r),
    .out_valid     (out_valid),
    .out_center    (out_center),
    .out_neighbor  (out_neighbor),
    .out_diff_x    (out_diff_x),
    .out_diff_y    (out_diff_y),
    .out_diff_z    (out_diff_z),
    .out_found     (out_found),
    .out_scan_done (out_scan_done)
  );

endmodule

// ===== sv/hnl_checker.sv =====
// Port-level checks of the half neighbor list scan, bound to the top level.
// Depends on hnl_pkg and half_neighbor_list_scan_assert.svh.
`include "half_neighbor_list_scan_assert.svh"

module hnl_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               start,
  input logic                               busy,
  input logic [1:0]                         in_op,
  input logic                               out_valid,
  input logic [hnl_pkg::IDX_W-1:0]          out_center,
  input logic [hnl_pkg::IDX_W-1:0]          out_neighbor,
  input logic signed [hnl_pkg::DIFF_W-1:0]  out_diff_x,
  input logic signed [hnl_pkg::DIFF_W-1:0]  out_diff_y,
  input logic signed [hnl_pkg::DIFF_W-1:0]  out_diff_z,
  input logic                               out_found,
  input logic                               out_scan_done
);

  `HNL_ASSERT_DELAY(a_scan_latency, start && !busy && in_op == hnl_pkg::OP_SCAN, 5, out_valid, "scan word missing")

  `HNL_ASSERT_IMPL(a_flags_strobed, out_found || out_scan_done, out_valid, "flag without strobe")

  `HNL_ASSERT_IMPL(a_half_order, out_found, out_neighbor <= out_center, "neighbor above center")

  `HNL_ASSERT_IMPL(a_miss_zero, out_valid && !out_found, out_center == 0 && out_neighbor == 0 && out_diff_x == 0 && out_diff_y == 0 && out_diff_z == 0, "miss carries payload")

  `HNL_ASSERT_IMPL(a_self_half, out_found && out_neighbor == out_center, out_diff_z > 0 || (out_diff_z == 0 && out_diff_y > 0) || (out_diff_z == 0 && out_diff_y == 0 && out_diff_x > 0), "self image not in half space")

endmodule

bind half_neighbor_list_scan hnl_checker u_hnl_checker (.*);

// ===== bench/tb_half_neighbor_list_scan.sv =====
`timescale 1ns / 100ps
// Self-checking bench for half_neighbor_list_scan: loads both stores, walks the
// scan order and checks every strobed word against a built-in predictor.
// Depends on hnl_pkg and the half_neighbor_list_scan RTL.
module tb_half_neighbor_list_scan;

  localparam int ATOM_DEPTH = 1024;
  localparam int TRANS_DEPTH = 256;
  localparam logic [1:0] OP_RESERVED = 2'd3;
  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 1500;
  localparam int SETTLE_CYCLES = 12;
  localparam longint CYCLE_LIMIT = 600000;
  localparam logic signed [hnl_pkg::COORD_W-1:0] COORD_MAX = 24'h7FFFFF;
  localparam logic signed [hnl_pkg::COORD_W-1:0] COORD_MIN = 24'h800000;

  typedef struct {
    logic [hnl_pkg::IDX_W-1:0]         center;
    logic [hnl_pkg::IDX_W-1:0]         neighbor;
    logic signed [hnl_pkg::DIFF_W-1:0] dx;
    logic signed [hnl_pkg::DIFF_W-1:0] dy;
    logic signed [hnl_pkg::DIFF_W-1:0] dz;
    logic                              found;
    logic                              done;
  } pair_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] in_op = '0;
  logic [hnl_pkg::SLOT_W-1:0] in_slot = '0;
  logic signed [hnl_pkg::COORD_W-1:0] in_coord_x = '0;
  logic signed [hnl_pkg::COORD_W-1:0] in_coord_y = '0;
  logic signed [hnl_pkg::COORD_W-1:0] in_coord_z = '0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [hnl_pkg::DIST_W-1:0] cfg_data = '0;
  logic out_valid;
  logic [hnl_pkg::IDX_W-1:0] out_center;
  logic [hnl_pkg::IDX_W-1:0] out_neighbor;
  logic signed [hnl_pkg::DIFF_W-1:0] out_diff_x;
  logic signed [hnl_pkg::DIFF_W-1:0] out_diff_y;
  logic signed [hnl_pkg::DIFF_W-1:0] out_diff_z;
  logic out_found;
  logic out_scan_done;

  // Predictor state: stores, cursors and registers as the block should hold them.
  hnl_pkg::vec_t pos_store [ATOM_DEPTH];
  hnl_pkg::vec_t trans_store [TRANS_DEPTH];
  bit pos_loaded [ATOM_DEPTH];
  bit trans_loaded [TRANS_DEPTH];
  int unsigned cur_i = 0;
  int unsigned cur_j = 0;
  int unsigned cur_t = 0;
  logic [hnl_pkg::DIST_W-1:0] cutoff_reg = '0;
  logic [10:0] atoms_reg = 11'd1;
  logic [8:0] trans_reg = 9'd1;

  pair_word_t pending_pairs [$];
  pair_word_t want_word;
  int mismatch_count = 0;
  longint cycle_count = 0;
  int item_count = 0;
  bit calm = 1'b0;
  int coord_scale = 23;

  half_neighbor_list_scan #(
    .MAX_ATOMS(ATOM_DEPTH),
    .MAX_TRANS(TRANS_DEPTH)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_op(in_op),
    .in_slot(in_slot),
    .in_coord_x(in_coord_x),
    .in_coord_y(in_coord_y),
    .in_coord_z(in_coord_z),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .out_valid(out_valid),
    .out_center(out_center),
    .out_neighbor(out_neighbor),
    .out_diff_x(out_diff_x),
    .out_diff_y(out_diff_y),
    .out_diff_z(out_diff_z),
    .out_found(out_found),
    .out_scan_done(out_scan_done)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int unsigned clamp_count(int unsigned n, int unsigned top);
    if (n == 0) return 1;
    return (n > top) ? top : n;
  endfunction

  // Restart the walk when the counts shrank below the cursors.
  function automatic void wrap_cursors();
    if (cur_i >= clamp_count(atoms_reg, ATOM_DEPTH) || cur_j > cur_i ||
        cur_t >= clamp_count(trans_reg, TRANS_DEPTH)) begin
      cur_i = 0;
      cur_j = 0;
      cur_t = 0;
    end
  endfunction

  function automatic void predict_scan();
    longint d [3];
    longint sq_len;
    bit keep;
    bit last;
    hnl_pkg::vec_t tv;
    hnl_pkg::vec_t pj;
    hnl_pkg::vec_t pc;
    pair_word_t w;
    wrap_cursors();
    tv = trans_store[cur_t];
    pj = pos_store[cur_j];
    pc = pos_store[cur_i];
    d[0] = longint'($signed(tv.x));
    d[1] = longint'($signed(tv.y));
    d[2] = longint'($signed(tv.z));
    if (cur_j < cur_i) begin
      d[0] += longint'($signed(pj.x)) - longint'($signed(pc.x));
      d[1] += longint'($signed(pj.y)) - longint'($signed(pc.y));
      d[2] += longint'($signed(pj.z)) - longint'($signed(pc.z));
    end
    sq_len = d[0] * d[0] + d[1] * d[1] + d[2] * d[2];
    keep = (sq_len != 0) && (sq_len < longint'(cutoff_reg));
    // Self images: keep only the lexicographically positive half.
    if (keep && cur_j == cur_i)
      keep = (d[2] > 0) || (d[2] == 0 && d[1] > 0) || (d[2] == 0 && d[1] == 0 && d[0] > 0);
    w.center = keep ? hnl_pkg::IDX_W'(cur_i) : '0;
    w.neighbor = keep ? hnl_pkg::IDX_W'(cur_j) : '0;
    w.dx = keep ? hnl_pkg::DIFF_W'(d[0]) : '0;
    w.dy = keep ? hnl_pkg::DIFF_W'(d[1]) : '0;
    w.dz = keep ? hnl_pkg::DIFF_W'(d[2]) : '0;
    w.found = keep;
    last = 1'b0;
    cur_t++;
    if (cur_t >= clamp_count(trans_reg, TRANS_DEPTH)) begin
      cur_t = 0;
      cur_j++;
      if (cur_j > cur_i) begin
        cur_j = 0;
        cur_i++;
        if (cur_i >= clamp_count(atoms_reg, ATOM_DEPTH)) begin
          cur_i = 0;
          last = 1'b1;
        end
      end
    end
    w.done = last;
    pending_pairs.push_back(w);
  endfunction

  function automatic void predict_word(logic [1:0] op, logic [hnl_pkg::SLOT_W-1:0] slot,
                                       hnl_pkg::vec_t v);
    case (op)
      hnl_pkg::OP_LOAD_POS: begin
        pos_store[slot] = v;
        pos_loaded[slot] = 1'b1;
      end
      hnl_pkg::OP_LOAD_TRANS: begin
        if (slot < TRANS_DEPTH) begin
          trans_store[slot] = v;
          trans_loaded[slot] = 1'b1;
        end
      end
      hnl_pkg::OP_SCAN: predict_scan();
      default: ;
    endcase
  endfunction

  function automatic hnl_pkg::vec_t mk_vec(int x, int y, int z);
    hnl_pkg::vec_t v;
    v.x = hnl_pkg::COORD_W'(x);
    v.y = hnl_pkg::COORD_W'(y);
    v.z = hnl_pkg::COORD_W'(z);
    return v;
  endfunction

  function automatic logic signed [hnl_pkg::COORD_W-1:0] rand_coord(int s);
    int v;
    v = int'($urandom_range(0, (1 << (s + 1)) - 1)) - (1 << s);
    return v[hnl_pkg::COORD_W-1:0];
  endfunction

  function automatic hnl_pkg::vec_t rand_vec(int s);
    hnl_pkg::vec_t v;
    v.x = rand_coord(s);
    v.y = rand_coord(s);
    v.z = rand_coord(s);
    return v;
  endfunction

  // Zero components often so the half rule sees its tie cases.
  function automatic hnl_pkg::vec_t rand_trans(int s);
    hnl_pkg::vec_t v;
    v = rand_vec(s);
    if ($urandom_range(99) < 30) v.x = '0;
    if ($urandom_range(99) < 30) v.y = '0;
    if ($urandom_range(99) < 30) v.z = '0;
    return v;
  endfunction

  task automatic send_word(logic [1:0] op, logic [hnl_pkg::SLOT_W-1:0] slot,
                           hnl_pkg::vec_t v);
    if (!calm)
      while ($urandom_range(99) < 24) begin
        start <= 1'b0;
        @(posedge clk);
      end
    start <= 1'b1;
    in_op <= op;
    in_slot <= slot;
    in_coord_x <= v.x;
    in_coord_y <= v.y;
    in_coord_z <= v.z;
    do @(posedge clk); while (busy !== 1'b0);
    predict_word(op, slot, v);
    if (op == hnl_pkg::OP_SCAN || op == hnl_pkg::OP_LOAD_POS ||
        (op == hnl_pkg::OP_LOAD_TRANS && slot < TRANS_DEPTH))
      item_count++;
  endtask

  // Load every entry the next candidate may read that was never written.
  task automatic scan_next();
    wrap_cursors();
    for (int k = 0; k <= int'(cur_i); k++)
      if (!pos_loaded[k])
        send_word(hnl_pkg::OP_LOAD_POS, hnl_pkg::SLOT_W'(k), rand_vec(coord_scale));
    for (int k = 0; k <= int'(cur_t); k++)
      if (!trans_loaded[k])
        send_word(hnl_pkg::OP_LOAD_TRANS, hnl_pkg::SLOT_W'(k), rand_trans(coord_scale));
    send_word(hnl_pkg::OP_SCAN, hnl_pkg::SLOT_W'($urandom), rand_vec(23));
  endtask

  // Hold off until every word is back, then let trailing loads retire.
  task automatic wait_idle();
    start <= 1'b0;
    while (pending_pairs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [hnl_pkg::DIST_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      hnl_pkg::REG_CUTOFF_SQ: cutoff_reg = data;
      hnl_pkg::REG_ATOM_COUNT: atoms_reg = data[10:0];
      hnl_pkg::REG_TRANS_COUNT: trans_reg = data[8:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Upper data bits are junk; only the low count bits matter.
  task automatic write_counts(int unsigned na, int unsigned nt);
    logic [hnl_pkg::DIST_W-1:0] a_word;
    logic [hnl_pkg::DIST_W-1:0] t_word;
    a_word = hnl_pkg::DIST_W'({$urandom, $urandom});
    t_word = hnl_pkg::DIST_W'({$urandom, $urandom});
    a_word[10:0] = 11'(na);
    t_word[8:0] = 9'(nt);
    write_reg(hnl_pkg::REG_ATOM_COUNT, a_word);
    write_reg(hnl_pkg::REG_TRANS_COUNT, t_word);
  endtask

  task automatic test_reset_values();
    coord_scale = 23;
    repeat (3) scan_next();
    send_word(OP_RESERVED, hnl_pkg::SLOT_W'($urandom), rand_vec(23));
  endtask

  task automatic test_directed_extremes();
    wait_idle();
    write_reg(hnl_pkg::REG_CUTOFF_SQ, '1);
    write_counts(2, 6);
    send_word(hnl_pkg::OP_LOAD_POS, hnl_pkg::SLOT_W'(0),
              mk_vec(COORD_MAX, COORD_MAX, COORD_MAX));
    send_word(hnl_pkg::OP_LOAD_POS, hnl_pkg::SLOT_W'(1),
              mk_vec(COORD_MIN, COORD_MIN, COORD_MIN));
    send_word(hnl_pkg::OP_LOAD_POS, hnl_pkg::SLOT_W'(1023), mk_vec(COORD_MAX, COORD_MIN, 0));
    send_word(hnl_pkg::OP_LOAD_TRANS, hnl_pkg::SLOT_W'(0), mk_vec(0, 0, 0));
    send_word(hnl_pkg::OP_LOAD_TRANS, hnl_pkg::SLOT_W'(1), mk_vec(1, 0, 0));
    send_word(hnl_pkg::OP_LOAD_TRANS, hnl_pkg::SLOT_W'(2), mk_vec(-1, 0, 0));
    send_word(hnl_pkg::OP_LOAD_TRANS, hnl_pkg::SLOT_W'(3), mk_vec(-7, 3, 0));
    send_word(hnl_pkg::OP_LOAD_TRANS, hnl_pkg::SLOT_W'(4),
              mk_vec(COORD_MAX, COORD_MIN, COORD_MAX));
    send_word(hnl_pkg::OP_LOAD_TRANS, hnl_pkg::SLOT_W'(5), mk_vec(0, 0, -1));
    // Beyond the translation store: drop.
    send_word(hnl_pkg::OP_LOAD_TRANS, hnl_pkg::SLOT_W'(1023),
              mk_vec(COORD_MIN, COORD_MAX, COORD_MIN));
    send_word(OP_RESERVED, hnl_pkg::SLOT_W'(0), mk_vec(0, 0, 0));
    repeat (18) scan_next();
  endtask

  task automatic test_count_limits();
    wait_idle();
    write_counts(0, 0);
    repeat (3) scan_next();
    wait_idle();
    write_reg(hnl_pkg::REG_CUTOFF_SQ, hnl_pkg::DIST_W'({$urandom, $urandom}));
    write_counts(2047, 511);
    repeat (40) scan_next();
    wait_idle();
    // Translation cursor now past the count: the walk restarts.
    write_counts(2047, 1);
    repeat (30) scan_next();
    wait_idle();
    write_counts(ATOM_DEPTH, TRANS_DEPTH);
    repeat (10) scan_next();
    wait_idle();
    write_reg(REG_UNUSED, hnl_pkg::DIST_W'({$urandom, $urandom}));
    write_counts(3, 2);
    repeat (14) scan_next();
    wait_idle();
    write_reg(hnl_pkg::REG_CUTOFF_SQ, hnl_pkg::DIST_W'(1));
    repeat (6) scan_next();
  endtask

  task automatic test_random_traffic();
    int phase;
    int target;
    int quota;
    int pick;
    int unsigned na;
    int unsigned nt;
    int slot_top;
    logic [hnl_pkg::DIST_W-1:0] cutoff;
    phase = 0;
    target = item_count + RANDOM_ITEMS;
    while (item_count < target) begin
      wait_idle();
      calm = (phase == 2);
      coord_scale = $urandom_range(4, 23);
      pick = $urandom_range(99);
      if (pick < 70) na = $urandom_range(1, 6);
      else if (pick < 92) na = $urandom_range(7, 40);
      else na = $urandom_range(41, 2047);
      nt = ($urandom_range(99) < 85) ? $urandom_range(1, 6) : $urandom_range(7, 511);
      write_counts(na, nt);
      pick = $urandom_range(99);
      if (pick < 8) cutoff = '0;
      else if (pick < 16) cutoff = '1;
      else cutoff = hnl_pkg::DIST_W'(longint'($urandom_range(1, 255)) << (2 * coord_scale - 6));
      write_reg(hnl_pkg::REG_CUTOFF_SQ, cutoff);
      quota = item_count + $urandom_range(80, 220);
      while (item_count < quota) begin
        pick = $urandom_range(99);
        if (pick < 80) begin
          scan_next();
        end else if (pick < 91) begin
          slot_top = (na + 2 > 1023) ? 1023 : na + 2;
          if ($urandom_range(99) < 20) slot_top = 1023;
          send_word(hnl_pkg::OP_LOAD_POS, hnl_pkg::SLOT_W'($urandom_range(0, slot_top)),
                    rand_vec(coord_scale));
        end else if (pick < 97) begin
          slot_top = (nt + 1 > TRANS_DEPTH - 1) ? TRANS_DEPTH - 1 : nt + 1;
          if ($urandom_range(99) < 20) slot_top = 1023;
          send_word(hnl_pkg::OP_LOAD_TRANS, hnl_pkg::SLOT_W'($urandom_range(0, slot_top)),
                    rand_trans(coord_scale));
        end else begin
          send_word(OP_RESERVED, hnl_pkg::SLOT_W'($urandom), rand_vec(23));
        end
      end
      phase++;
    end
    calm = 1'b0;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) begin
      if (pending_pairs.size() == 0) begin
        if (mismatch_count < 10)
          $display("unexpected word: center %0d neighbor %0d found %0b done %0b",
                   out_center, out_neighbor, out_found, out_scan_done);
        mismatch_count++;
      end else begin
        want_word = pending_pairs.pop_front();
        if (out_center !== want_word.center || out_neighbor !== want_word.neighbor ||
            out_diff_x !== want_word.dx || out_diff_y !== want_word.dy ||
            out_diff_z !== want_word.dz || out_found !== want_word.found ||
            out_scan_done !== want_word.done) begin
          if (mismatch_count < 10) begin
            $display("mismatch exp: c %0d n %0d d (%0d %0d %0d) found %0b done %0b",
                     want_word.center, want_word.neighbor, want_word.dx, want_word.dy,
                     want_word.dz, want_word.found, want_word.done);
            $display("         got: c %0d n %0d d (%0d %0d %0d) found %0b done %0b",
                     out_center, out_neighbor, out_diff_x, out_diff_y, out_diff_z,
                     out_found, out_scan_done);
          end
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_values();
    test_directed_extremes();
    test_count_limits();
    test_random_traffic();
    wait_idle();
    if (mismatch_count == 0 && pending_pairs.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
